/* src/chbf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chbf_pkg
// Shared types and constants for the chunked body framer.
// ----------------------------------------------------------------------------
package chbf_pkg;

  localparam int unsigned CntW = 22;
  localparam logic [CntW-1:0] CntMask = {CntW{1'b1}};
  localparam logic [CntW-1:0] WindowMax = CntW'(2097152);

  localparam int unsigned TokDepth = 4;
  localparam int unsigned TokPtrW = $clog2(TokDepth);
  localparam int unsigned ResDepth = 2;
  localparam int unsigned ResPtrW = $clog2(ResDepth);

  localparam logic [1:0] DpNone   = 2'd0;
  localparam logic [1:0] DpZero   = 2'd1;
  localparam logic [1:0] DpPrefix = 2'd2;
  localparam logic [1:0] DpDigits = 2'd3;

  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChTab  = 8'h09;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChSemi = 8'h3B;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_BAD   = 2'd1,
    ST_SHORT = 2'd2
  } chbf_status_e;

  typedef enum logic [11:0] {
    PH_IDLE     = 12'b0000_0000_0001,
    PH_SZ_LEAD  = 12'b0000_0000_0010,
    PH_SZ_NUM   = 12'b0000_0000_0100,
    PH_SZ_TRAIL = 12'b0000_0000_1000,
    PH_SZ_EXT   = 12'b0000_0001_0000,
    PH_SZ_BAD   = 12'b0000_0010_0000,
    PH_DATA     = 12'b0000_0100_0000,
    PH_DATA_END = 12'b0000_1000_0000,
    PH_DATA_CR  = 12'b0001_0000_0000,
    PH_TR_START = 12'b0010_0000_0000,
    PH_TR_CR    = 12'b0100_0000_0000,
    PH_TR_BODY  = 12'b1000_0000_0000
  } chbf_phase_e;

  typedef struct packed {
    logic       start;
    logic       last;
    logic       is_lf;
    logic       is_cr;
    logic       is_space;
    logic       is_semi;
    logic       is_x;
    logic       is_hex;
    logic [3:0] hex_val;
  } chbf_tok_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [CntW-1:0] length;
  } chbf_res_t;

  function automatic chbf_tok_t chbf_classify(input logic start, input logic [7:0] c,
                                              input logic last);
    chbf_tok_t t;
    t.start    = start;
    t.last     = last;
    t.is_lf    = (c == ChLf);
    t.is_cr    = (c == ChCr);
    t.is_space = (c == ChSp) || (c == ChTab) || (c == ChCr);
    t.is_semi  = (c == ChSemi);
    t.is_x     = (c == 8'h78) || (c == 8'h58);
    t.is_hex   = 1'b1;
    t.hex_val  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      t.hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t.hex_val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t.hex_val = 4'(c - 8'h37);
    end else begin
      t.is_hex = 1'b0;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

/* src/http_chunked_body_framer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_framer_core
// Finds the end of an HTTP/1.1 chunked body and reports its status and length.
// Result path: the token of the body's last byte waits in the token queue,
//   then the parser puts the result in the result queue behind older ones.
// Throughput: one byte per cycle while not full, one parser step per byte.
// Reset: both queues empty, parser idle, bytes ignored until a start byte.
// ----------------------------------------------------------------------------
module http_chunked_body_framer_core import chbf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic             start_req_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_i,
  output logic                  empty,
  input  wire logic             pop,
  output logic [1:0]            status_o,
  output logic [CntW-1:0]       body_length_o
);

  logic      tok_valid;
  logic      tok_pop;
  chbf_tok_t tok;

  chbf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .start_req_i (start_req_i),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  chbf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_valid_i   (tok_valid),
    .tok_i         (tok),
    .tok_pop_o     (tok_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .status_o      (status_o),
    .body_length_o (body_length_o)
  );

  a_tok_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pop |-> tok_valid)
    else $error("token transfer from empty queue");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == ST_DONE || status_o == ST_BAD || status_o == ST_SHORT))
    else $error("undefined status code");

  a_len_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_DONE) |-> (body_length_o == '0))
    else $error("nonzero length on failed body");

  a_len_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_DONE) |-> (body_length_o != '0))
    else $error("zero length on complete body");

endmodule
`default_nettype wire

/* src/chbf_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chbf_front
// Accepts body bytes, classifies each one and queues the tokens.
// ----------------------------------------------------------------------------
module chbf_front import chbf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic       start_req_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_i,
  output logic            tok_valid_o,
  output chbf_tok_t       tok_o,
  input  wire logic       tok_pop_i
);

  chbf_tok_t          mem_q [TokDepth];
  logic [TokPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [TokPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [TokPtrW:0]   cnt_q, cnt_d;
  logic               wr_en;
  logic               rd_en;

  assign full_o      = (cnt_q == (TokPtrW+1)'(TokDepth));
  assign tok_valid_o = (cnt_q != '0);
  assign tok_o       = mem_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = tok_pop_i && tok_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (TokPtrW+1)'(wr_en) - (TokPtrW+1)'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= chbf_classify(start_req_i, data_byte_i, last_i);
    end
  end

endmodule
`default_nettype wire

/* src/chbf_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chbf_back
// Runs the chunk parser on queued tokens and holds results for the consumer.
// ----------------------------------------------------------------------------
module chbf_back import chbf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             tok_valid_i,
  input  wire chbf_tok_t        tok_i,
  output logic                  tok_pop_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output logic [1:0]            status_o,
  output logic [CntW-1:0]       body_length_o
);

  chbf_phase_e     ph_q, ph_d, ph_e;
  logic [CntW-1:0] rem_q, rem_d, rem_e, rem_dec;
  logic            ovf_q, ovf_d, ovf_e;
  logic [1:0]      dp_q, dp_d, dp_e;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_e, cnt_n;
  logic            fin;
  chbf_status_e    st;
  logic            res_push;
  chbf_res_t       res_new;

  chbf_res_t          res_mem_q [ResDepth];
  logic [ResPtrW-1:0] res_wr_q, res_rd_q;
  logic [ResPtrW:0]   res_cnt_q;
  logic               res_pop;

  assign tok_pop_o = tok_valid_i && (res_cnt_q != (ResPtrW+1)'(ResDepth));
  assign rem_dec   = rem_e - 1'b1;

  always_comb begin
    ph_e  = tok_i.start ? PH_SZ_LEAD : ph_q;
    rem_e = tok_i.start ? '0 : rem_q;
    ovf_e = tok_i.start ? 1'b0 : ovf_q;
    dp_e  = tok_i.start ? DpNone : dp_q;
    cnt_e = tok_i.start ? '0 : cnt_q;
    cnt_n = (cnt_e != CntMask) ? cnt_e + 1'b1 : cnt_e;

    ph_d     = ph_q;
    rem_d    = rem_q;
    ovf_d    = ovf_q;
    dp_d     = dp_q;
    cnt_d    = cnt_q;
    fin      = 1'b0;
    st       = ST_DONE;
    res_push = 1'b0;
    res_new  = '0;

    if (tok_pop_o) begin
      ph_d  = ph_e;
      rem_d = rem_e;
      ovf_d = ovf_e;
      dp_d  = dp_e;
      cnt_d = cnt_e;
      if (ph_e != PH_IDLE) begin
        cnt_d = cnt_n;
        unique case (ph_e) inside
          PH_SZ_LEAD, PH_SZ_NUM, PH_SZ_TRAIL, PH_SZ_EXT, PH_SZ_BAD: begin
            if (tok_i.is_lf) begin
              if (ph_e == PH_SZ_BAD || ovf_e || !(dp_e == DpZero || dp_e == DpDigits)) begin
                fin = 1'b1;
                st  = ST_BAD;
              end else begin
                ph_d = (rem_e == '0) ? PH_TR_START : PH_DATA;
              end
            end else if (ph_e == PH_SZ_BAD || ph_e == PH_SZ_EXT) begin
              ph_d = ph_e;
            end else if (tok_i.is_semi) begin
              ph_d = PH_SZ_EXT;
            end else if (tok_i.is_space) begin
              if (ph_e == PH_SZ_NUM) begin
                ph_d = PH_SZ_TRAIL;
              end
            end else if (ph_e == PH_SZ_TRAIL) begin
              ph_d = PH_SZ_BAD;
            end else begin
              ph_d = PH_SZ_NUM;
              if (dp_e == DpZero && tok_i.is_x) begin
                dp_d = DpPrefix;
              end else if (!tok_i.is_hex) begin
                ph_d = PH_SZ_BAD;
              end else if (dp_e == DpNone && tok_i.hex_val == 4'd0) begin
                dp_d  = DpZero;
                rem_d = '0;
              end else begin
                ovf_d = ovf_e | (|rem_e[CntW-1:CntW-4]);
                rem_d = {rem_e[CntW-5:0], tok_i.hex_val};
                dp_d  = DpDigits;
              end
            end
          end
          PH_DATA: begin
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              ph_d = PH_DATA_END;
            end
          end
          PH_DATA_END: begin
            if (tok_i.is_cr) begin
              ph_d = PH_DATA_CR;
            end else if (tok_i.is_lf) begin
              ph_d  = PH_SZ_LEAD;
              rem_d = '0;
              ovf_d = 1'b0;
              dp_d  = DpNone;
            end else begin
              fin = 1'b1;
              st  = ST_BAD;
            end
          end
          PH_DATA_CR: begin
            if (tok_i.is_lf) begin
              ph_d  = PH_SZ_LEAD;
              rem_d = '0;
              ovf_d = 1'b0;
              dp_d  = DpNone;
            end else begin
              fin = 1'b1;
              st  = ST_BAD;
            end
          end
          PH_TR_START: begin
            if (tok_i.is_lf) begin
              fin = 1'b1;
            end else begin
              ph_d = tok_i.is_cr ? PH_TR_CR : PH_TR_BODY;
            end
          end
          PH_TR_CR: begin
            if (tok_i.is_lf) begin
              fin = 1'b1;
            end else begin
              ph_d = PH_TR_BODY;
            end
          end
          PH_TR_BODY: begin
            if (tok_i.is_lf) begin
              ph_d = PH_TR_START;
            end
          end
          default: begin
            ph_d = ph_e;
          end
        endcase
        if (!fin && (tok_i.last || cnt_n >= WindowMax)) begin
          fin = 1'b1;
          st  = ST_SHORT;
        end
        if (fin) begin
          res_push       = 1'b1;
          res_new.status = st;
          res_new.length = (st == ST_DONE) ? cnt_n : '0;
          ph_d           = PH_IDLE;
          rem_d          = '0;
          ovf_d          = 1'b0;
          dp_d           = DpNone;
          cnt_d          = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      rem_q <= '0;
      ovf_q <= 1'b0;
      dp_q  <= DpNone;
      cnt_q <= '0;
    end else begin
      ph_q  <= ph_d;
      rem_q <= rem_d;
      ovf_q <= ovf_d;
      dp_q  <= dp_d;
      cnt_q <= cnt_d;
    end
  end

  assign empty_o       = (res_cnt_q == '0);
  assign res_pop       = pop_i && !empty_o;
  assign status_o      = res_mem_q[res_rd_q].status;
  assign body_length_o = res_mem_q[res_rd_q].length;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (res_push) begin
        res_wr_q <= res_wr_q + 1'b1;
      end
      if (res_pop) begin
        res_rd_q <= res_rd_q + 1'b1;
      end
      res_cnt_q <= res_cnt_q + (ResPtrW+1)'(res_push) - (ResPtrW+1)'(res_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_new;
    end
  end

endmodule
`default_nettype wire
